>>> rtl/core/jtp_pkg.sv
// ----------------------------------------------------------------------------
// jtp_pkg
// Shared types and constants of the jump trajectory profiler: register
// indexes, phase codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package jtp_pkg;

    localparam int POS_BITS_DEF  = 18;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TICK_W        = 16;
    localparam int CNT_W         = 18;
    localparam int BND_W         = 19;
    localparam int CFG_IDX_W     = 3;
    localparam int PHASE_W       = 3;

    localparam int CROUCH_TICKS_RST  = 300;
    localparam int LIFT_TICKS_RST    = 100;
    localparam int LAND_TICKS_RST    = 100;
    localparam int FLIGHT_TICKS_RST  = 300;
    localparam int CROUCH_HEIGHT_RST = -9830;
    localparam int FLIGHT_HEIGHT_RST = -16384;
    localparam int RISE_HEIGHT_RST   = -13107;
    localparam int BACK_DISTANCE_RST = 3277;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROUCH_TICKS,
        CFG_LIFT_TICKS,
        CFG_LAND_TICKS,
        CFG_FLIGHT_TICKS,
        CFG_CROUCH_HEIGHT,
        CFG_FLIGHT_HEIGHT,
        CFG_RISE_HEIGHT,
        CFG_BACK_DISTANCE
    } t_cfg_idx;

    typedef enum logic [PHASE_W-1:0] {
        PH_CROUCH,
        PH_LIFT,
        PH_HOLD,
        PH_LAND,
        PH_RISE,
        PH_IDLE
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PHASE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MULX,
        S_MULZ,
        S_FIN,
        S_PUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PP,
        MUL_QG,
        MUL_X,
        MUL_Z
    } t_mul_op;

    typedef struct packed {
        logic    load_in;
        logic    decode;
        logic    classify;
        logic    div_step;
        t_mul_op mul_op;
        logic    fin;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
    } t_dp_sts;

endpackage

>>> rtl/core/jtp_datapath.sv
// ----------------------------------------------------------------------------
// jtp_datapath
// Configuration registers, tick counter, phase selection, restoring divider
// for the phase progress and one shared multiplier for smoothstep and blends.
// ----------------------------------------------------------------------------
module jtp_datapath import jtp_pkg::*; #(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CFG_W     = (POS_BITS > TICK_W) ? POS_BITS : TICK_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wr_data,
    input  logic                       i_command,
    input  logic signed [POS_BITS-1:0] i_start_height,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    output logic signed [POS_BITS-1:0] o_target_x,
    output logic signed [POS_BITS-1:0] o_target_z,
    output logic [PHASE_W-1:0]         o_phase
);

    localparam int SW = FRAC_BITS + 1;
    localparam int GW = FRAC_BITS + 2;
    localparam int AW = (POS_BITS + 2 > FRAC_BITS + 3) ? POS_BITS + 2 : FRAC_BITS + 3;
    localparam int BW = FRAC_BITS + 3;
    localparam int PW = AW + BW;
    localparam logic [SW-1:0] ONE       = SW'(1) << FRAC_BITS;
    localparam logic [GW-1:0] THREE_ONE = GW'(3) << FRAC_BITS;

    // configuration
    logic [TICK_W-1:0]          r_crouch_ticks, r_lift_ticks, r_land_ticks, r_flight_ticks;
    logic signed [POS_BITS-1:0] r_crouch_h, r_flight_h, r_rise_h, r_back_d;

    // jump state
    logic [CNT_W-1:0]           r_tick;
    logic signed [POS_BITS-1:0] r_entry, r_held_x, r_held_z;

    // phase boundaries
    logic signed [BND_W-1:0]    r_b_lift, r_b_hold, r_b_fall;
    logic [CNT_W-1:0]           r_total;

    logic                       r_cmd_bit;
    logic signed [POS_BITS-1:0] r_height;
    t_phase                     r_res_phase;

    logic [TICK_W:0]            r_rem;
    logic [TICK_W-1:0]          r_den;
    logic [FRAC_BITS-1:0]       r_quo;
    logic                       r_sat;

    logic signed [POS_BITS-1:0] r_ax, r_az;
    logic signed [POS_BITS:0]   r_dx, r_dz;
    logic signed [PW-1:0]       r_prod;
    logic [SW-1:0]              r_s;
    logic signed [POS_BITS-1:0] r_x_new;

    logic signed [POS_BITS-1:0] r_out_x, r_out_z;
    t_phase                     r_out_phase;

    logic signed [BND_W-1:0]    w_c, w_l, w_d, w_f, w_t;
    t_phase                     n_phase;
    logic [TICK_W:0]            n_num;
    logic [TICK_W-1:0]          n_den;
    logic signed [POS_BITS-1:0] n_ax, n_bx, n_az, n_bz;
    logic                       n_sat;

    logic [TICK_W:0]            w_rem2;
    logic                       w_ge;
    logic [SW-1:0]              w_p, w_q;
    logic [GW-1:0]              w_g;
    logic signed [AW-1:0]       w_mul_a;
    logic signed [BW-1:0]       w_mul_b;
    logic signed [PW-1:0]       w_prod;

    assign w_c = $signed(BND_W'(r_crouch_ticks));
    assign w_l = $signed(BND_W'(r_lift_ticks));
    assign w_d = $signed(BND_W'(r_land_ticks));
    assign w_f = $signed(BND_W'(r_flight_ticks));
    assign w_t = $signed(BND_W'(r_tick));

    assign o_sts.skip = !r_cmd_bit || (r_tick >= r_total);

    // phase select on the already advanced tick count
    always_comb begin
        n_phase = PH_RISE;
        n_num   = (TICK_W+1)'(w_t - r_b_fall);
        n_den   = r_crouch_ticks;
        n_ax    = '0;
        n_bx    = '0;
        n_az    = r_crouch_h;
        n_bz    = r_rise_h;
        if (w_t < w_c) begin
            n_phase = PH_CROUCH;
            n_num   = (TICK_W+1)'(w_t);
            n_den   = r_crouch_ticks;
            n_az    = r_entry;
            n_bz    = r_crouch_h;
        end else if (w_t < r_b_lift) begin
            n_phase = PH_LIFT;
            n_num   = (TICK_W+1)'(w_t - w_c);
            n_den   = r_lift_ticks;
            n_bx    = r_back_d;
            n_az    = r_crouch_h;
            n_bz    = r_flight_h;
        end else if (w_t < r_b_hold) begin
            // den of zero forces full progress, blend lands on the end point
            n_phase = PH_HOLD;
            n_num   = '0;
            n_den   = '0;
            n_ax    = r_back_d;
            n_bx    = r_back_d;
            n_az    = r_flight_h;
            n_bz    = r_flight_h;
        end else if (w_t < r_b_fall) begin
            n_phase = PH_LAND;
            n_num   = (TICK_W+1)'(w_t - r_b_hold);
            n_den   = r_land_ticks;
            n_ax    = r_back_d;
            n_az    = r_flight_h;
            n_bz    = r_crouch_h;
        end
        n_sat = (n_den == '0) || (n_num >= {1'b0, n_den});
    end

    assign w_rem2 = {r_rem[TICK_W-1:0], 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_p    = r_sat ? ONE : {1'b0, r_quo};
    assign w_g    = THREE_ONE - {w_p, 1'b0};
    assign w_q    = r_prod[FRAC_BITS +: SW];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_op)
            MUL_PP: begin
                w_mul_a = $signed(AW'(w_p));
                w_mul_b = $signed(BW'(w_p));
            end
            MUL_QG: begin
                w_mul_a = $signed(AW'(w_g));
                w_mul_b = $signed(BW'(w_q));
            end
            MUL_X: begin
                w_mul_a = AW'(r_dx);
                w_mul_b = $signed(BW'(w_q));
            end
            MUL_Z: begin
                w_mul_a = AW'(r_dz);
                w_mul_b = $signed(BW'(r_s));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crouch_ticks <= TICK_W'(CROUCH_TICKS_RST);
            r_lift_ticks   <= TICK_W'(LIFT_TICKS_RST);
            r_land_ticks   <= TICK_W'(LAND_TICKS_RST);
            r_flight_ticks <= TICK_W'(FLIGHT_TICKS_RST);
            r_crouch_h     <= POS_BITS'(CROUCH_HEIGHT_RST);
            r_flight_h     <= POS_BITS'(FLIGHT_HEIGHT_RST);
            r_rise_h       <= POS_BITS'(RISE_HEIGHT_RST);
            r_back_d       <= POS_BITS'(BACK_DISTANCE_RST);
            r_tick         <= '0;
            r_entry        <= '0;
            r_held_x       <= '0;
            r_held_z       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_CROUCH_TICKS:  r_crouch_ticks <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_LIFT_TICKS:    r_lift_ticks   <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_LAND_TICKS:    r_land_ticks   <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_FLIGHT_TICKS:  r_flight_ticks <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_CROUCH_HEIGHT: r_crouch_h     <= i_cfg_wr_data[POS_BITS-1:0];
                    CFG_FLIGHT_HEIGHT: r_flight_h     <= i_cfg_wr_data[POS_BITS-1:0];
                    CFG_RISE_HEIGHT:   r_rise_h       <= i_cfg_wr_data[POS_BITS-1:0];
                    CFG_BACK_DISTANCE: r_back_d       <= i_cfg_wr_data[POS_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.decode) begin
                if (!r_cmd_bit) begin
                    r_entry <= r_height;
                    r_tick  <= '0;
                end else if (r_tick < r_total) begin
                    r_tick <= r_tick + CNT_W'(1);
                end
            end
            if (i_cmd.fin) begin
                r_held_x <= r_x_new;
                r_held_z <= r_az + r_prod[FRAC_BITS +: POS_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_lift <= w_c + w_l;
        r_b_fall <= w_c + w_f;
        r_b_hold <= w_c + w_f - w_d;
        r_total  <= CNT_W'(r_crouch_ticks) + CNT_W'(r_crouch_ticks) + CNT_W'(r_flight_ticks);

        if (i_cmd.load_in) begin
            r_cmd_bit <= i_command;
            r_height  <= i_start_height;
        end
        if (i_cmd.decode) begin
            r_res_phase <= PH_IDLE;
        end
        if (i_cmd.classify) begin
            r_res_phase <= n_phase;
            r_rem       <= n_num;
            r_den       <= n_den;
            r_sat       <= n_sat;
            r_quo       <= '0;
            r_ax        <= n_ax;
            r_az        <= n_az;
            r_dx        <= (POS_BITS+1)'(n_bx) - (POS_BITS+1)'(n_ax);
            r_dz        <= (POS_BITS+1)'(n_bz) - (POS_BITS+1)'(n_az);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_quo <= {r_quo[FRAC_BITS-2:0], w_ge};
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_op == MUL_X) begin
            r_s <= w_q;
        end
        if (i_cmd.mul_op == MUL_Z) begin
            r_x_new <= r_ax + r_prod[FRAC_BITS +: POS_BITS];
        end
        if (i_cmd.load_out) begin
            r_out_x     <= r_held_x;
            r_out_z     <= r_held_z;
            r_out_phase <= r_res_phase;
        end
    end

    assign o_target_x = r_out_x;
    assign o_target_z = r_out_z;
    assign o_phase    = r_out_phase;

endmodule

>>> rtl/core/jtp_ctrl.sv
// ----------------------------------------------------------------------------
// jtp_ctrl
// Sequencer for one request: decode, phase select, divide, four multiplies,
// then hand the result out; a start or finished jump goes straight to output.
// ----------------------------------------------------------------------------
module jtp_ctrl import jtp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int DCW = $clog2(FRAC_BITS);

    t_state         r_state, n_state;
    logic [DCW-1:0] r_div_cnt, n_div_cnt;
    logic           r_out_valid, n_out_valid;
    logic           w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_sts.skip ? S_PUT : S_PHASE;
            end
            S_PHASE: begin
                o_cmd.classify = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DCW'(1);
                if (r_div_cnt == DCW'(FRAC_BITS - 1)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_op = MUL_PP;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_op = MUL_QG;
                n_state      = S_MULX;
            end
            S_MULX: begin
                o_cmd.mul_op = MUL_X;
                n_state      = S_MULZ;
            end
            S_MULZ: begin
                o_cmd.mul_op = MUL_Z;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    a_accept_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted request did not move to decode");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_div_cnt == DCW'(FRAC_BITS - 1)) |=> (r_state == S_MUL1))
        else $error("divider did not hand over after the last quotient bit");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && !w_out_free) |=> (r_state == S_PUT))
        else $error("pending result left before the output register was free");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

>>> rtl/core/jump_trajectory_profiler_top.sv
// ----------------------------------------------------------------------------
// jump_trajectory_profiler_top
// Foot-target generator for one jump: crouch, lift, hold, land and rise
// blended with a smoothstep of the phase progress.
// ----------------------------------------------------------------------------
// One request is worked at a time. A start request, or a tick after the jump
// has finished, returns the held target straight after decode; a tick inside
// the jump runs the one-bit-per-cycle restoring divider for the progress and
// the four passes through the single shared multiplier. The output register
// lets the next request be taken while a result still waits downstream.
// Configuration writes land directly in the registers and must come while no
// request is in flight.
module jump_trajectory_profiler_top import jtp_pkg::*; #(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CFG_W    = (POS_BITS > TICK_W) ? POS_BITS : TICK_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic signed [POS_BITS-1:0] i_start_height,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [POS_BITS-1:0] o_target_x,
    output logic signed [POS_BITS-1:0] o_target_z,
    output logic [PHASE_W-1:0]         o_phase
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    jtp_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    jtp_datapath #(
        .POS_BITS  (POS_BITS),
        .FRAC_BITS (FRAC_BITS),
        .CFG_W     (CFG_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_command),
        .i_start_height (i_start_height),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_target_x     (o_target_x),
        .o_target_z     (o_target_z),
        .o_phase        (o_phase)
    );

endmodule

>>> test/tb_jump_trajectory_profiler_top.sv
// ----------------------------------------------------------------------------
// tb_jump_trajectory_profiler_top
// Self-checking bench for the jump trajectory profiler. A clocked driver sends
// start and tick requests from a queue and a clocked monitor checks every
// foot target against a built-in smoothstep predictor. The run covers several
// register settings (the extremes too) and random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_jump_trajectory_profiler_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jtp_pkg::*;

    localparam int PW = POS_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam int CW = (PW > TICK_W) ? PW : TICK_W;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;
    localparam logic signed [PW-1:0] HMIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] HMAX = {1'b0, {(PW-1){1'b1}}};

    typedef struct {
        logic                 command;
        logic signed [PW-1:0] height;
    } t_jump_req;

    typedef struct {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] z;
        t_phase               ph;
    } t_target;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CW-1:0]        i_cfg_wr_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_command = CMD_START;
    logic signed [PW-1:0] i_start_height = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [PW-1:0] o_target_x;
    logic signed [PW-1:0] o_target_z;
    logic [PHASE_W-1:0]   o_phase;

    t_jump_req jump_reqs[$];
    t_target   due_targets[$];

    // predictor copy of the registers and the jump state
    longint len_crouch = CROUCH_TICKS_RST;
    longint len_lift   = LIFT_TICKS_RST;
    longint len_land   = LAND_TICKS_RST;
    longint len_flight = FLIGHT_TICKS_RST;
    longint z_crouch   = CROUCH_HEIGHT_RST;
    longint z_flight   = FLIGHT_HEIGHT_RST;
    longint z_rise     = RISE_HEIGHT_RST;
    longint x_back     = BACK_DISTANCE_RST;
    longint jump_ticks = 0;
    longint launch_z   = 0;
    longint hold_x     = 0;
    longint hold_z     = 0;

    int   err_count = 0;
    int   reqs_taken = 0;
    int   targets_checked = 0;
    int   settings_count = 0;
    int   sent_count = 0;
    bit [7:0] seen_phases = '0;
    bit   in_fire = 1'b0;
    bit   req_live = 1'b0;
    bit   drain_hold = 1'b0;
    bit   quiet = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;

    jump_trajectory_profiler_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_start_height (i_start_height),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_target_x     (o_target_x),
        .o_target_z     (o_target_z),
        .o_phase        (o_phase)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned ease(longint unsigned num, longint unsigned den);
        longint unsigned one;
        longint unsigned p;
        longint unsigned q;
        one = 64'd1 << FW;
        if (den == 0 || num >= den) begin
            p = one;
        end else begin
            p = (num << FW) / den;
        end
        q = (p * p) >> FW;
        return (q * (3 * one - 2 * p)) >> FW;
    endfunction

    // floor of the scaled step keeps the blend between its end points
    function automatic longint mix(longint a, longint b, longint unsigned s);
        longint prod;
        prod = (b - a) * longint'(s);
        return a + (prod >>> FW);
    endfunction

    task automatic step_jump(input logic cmd, input logic signed [PW-1:0] h,
                             output t_target res);
        longint t;
        longint c;
        longint l;
        longint d;
        longint f;
        t_phase ph;
        ph = PH_IDLE;
        c = len_crouch;
        l = len_lift;
        d = len_land;
        f = len_flight;
        if (cmd == CMD_START) begin
            launch_z = h;
            jump_ticks = 0;
        end else if (jump_ticks < 2 * c + f) begin
            jump_ticks++;
            t = jump_ticks;
            if (t < c) begin
                hold_x = 0;
                hold_z = mix(launch_z, z_crouch, ease(t, c));
                ph = PH_CROUCH;
            end else if (t < c + l) begin
                hold_x = mix(0, x_back, ease(t - c, l));
                hold_z = mix(z_crouch, z_flight, ease(t - c, l));
                ph = PH_LIFT;
            end else if (t < c + f - d) begin
                hold_x = x_back;
                hold_z = z_flight;
                ph = PH_HOLD;
            end else if (t < c + f) begin
                hold_x = mix(x_back, 0, ease(t - (c + f - d), d));
                hold_z = mix(z_flight, z_crouch, ease(t - (c + f - d), d));
                ph = PH_LAND;
            end else begin
                hold_x = 0;
                hold_z = mix(z_crouch, z_rise, ease(t - c - f, c));
                ph = PH_RISE;
            end
        end
        res.x = hold_x[PW-1:0];
        res.z = hold_z[PW-1:0];
        res.ph = ph;
    endtask

    task automatic note_error(string what, longint got, longint want);
        err_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [PW-1:0] any_height();
        logic signed [PW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = HMIN;
            1: v = HMAX;
            2: v = '0;
            3: v = '1;
            default: v = PW'($urandom());
        endcase
        return v;
    endfunction

    // monitor: check results first, then take the request predicted on this edge
    always @(posedge i_clk) begin : watch_ports
        t_target want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_targets.size() == 0) begin
                    note_error("target with no request pending", o_phase, PH_IDLE);
                end else begin
                    want = due_targets.pop_front();
                    if (o_target_x !== want.x) note_error("target_x", o_target_x, want.x);
                    if (o_target_z !== want.z) note_error("target_z", o_target_z, want.z);
                    if (o_phase !== want.ph) note_error("phase", o_phase, want.ph);
                    seen_phases[o_phase] = 1'b1;
                    targets_checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_fire = 1'b1;
                step_jump(i_command, i_start_height, want);
                due_targets.push_back(want);
                reqs_taken++;
            end
        end
    end

    always @(negedge i_clk) begin : drive_reqs
        logic      nv;
        t_jump_req r;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (in_fire) begin
                req_live = 1'b0;
                nv = 1'b0;
            end
            if (!req_live) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_hold) begin
                    if (due_targets.size() == 0) drain_hold = 1'b0;
                end else if (jump_reqs.size() > 0) begin
                    r = jump_reqs.pop_front();
                    i_command <= r.command;
                    i_start_height <= r.height;
                    nv = 1'b1;
                    req_live = 1'b1;
                    sent_count++;
                    gap_left = quiet ? 0 : pick_pause();
                    // hold off until the pipe is empty
                    if (sent_count == 40 || (!quiet && $urandom_range(0, 99) == 0)) begin
                        drain_hold = 1'b1;
                    end
                end
            end
        end
        i_in_valid <= nv;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 2) == 0) begin
            stall_left = pick_pause();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic set_reg(t_cfg_idx idx, logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wr_data <= val;
        case (idx)
            CFG_CROUCH_TICKS:  len_crouch = val[TICK_W-1:0];
            CFG_LIFT_TICKS:    len_lift = val[TICK_W-1:0];
            CFG_LAND_TICKS:    len_land = val[TICK_W-1:0];
            CFG_FLIGHT_TICKS:  len_flight = val[TICK_W-1:0];
            CFG_CROUCH_HEIGHT: z_crouch = $signed(val[PW-1:0]);
            CFG_FLIGHT_HEIGHT: z_flight = $signed(val[PW-1:0]);
            CFG_RISE_HEIGHT:   z_rise = $signed(val[PW-1:0]);
            CFG_BACK_DISTANCE: x_back = $signed(val[PW-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic program_jump(int c, int l, int d, int f,
                                logic signed [PW-1:0] ch, logic signed [PW-1:0] fh,
                                logic signed [PW-1:0] rh, logic signed [PW-1:0] bk);
        set_reg(CFG_CROUCH_TICKS, CW'(c));
        set_reg(CFG_LIFT_TICKS, CW'(l));
        set_reg(CFG_LAND_TICKS, CW'(d));
        set_reg(CFG_FLIGHT_TICKS, CW'(f));
        set_reg(CFG_CROUCH_HEIGHT, CW'(ch));
        set_reg(CFG_FLIGHT_HEIGHT, CW'(fh));
        set_reg(CFG_RISE_HEIGHT, CW'(rh));
        set_reg(CFG_BACK_DISTANCE, CW'(bk));
        settings_count++;
    endtask

    task automatic push_req(logic cmd, logic signed [PW-1:0] h);
        t_jump_req r;
        r.command = cmd;
        r.height = h;
        jump_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (jump_reqs.size() != 0 || req_live || due_targets.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int k;
        int n;
        int r;
        int ticks;
        int pc;
        int pf;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ticks straight out of reset run from height zero
        push_req(CMD_TICK, '0);
        push_req(CMD_TICK, HMAX);
        push_req(CMD_START, HMIN);
        push_req(CMD_TICK, '0);
        push_req(CMD_START, HMAX);
        push_req(CMD_TICK, HMIN);
        wait_idle();

        // short jump through every phase, then ticks after done
        program_jump(2, 2, 2, 5, HMAX, HMIN, '0, HMIN);
        push_req(CMD_START, '0);
        repeat (12) push_req(CMD_TICK, any_height());
        wait_idle();

        // shrink the jump under a running counter
        program_jump(10, 3, 3, 6, '1, PW'(65536), PW'(-65536), HMAX);
        push_req(CMD_START, '1);
        repeat (4) push_req(CMD_TICK, '0);
        wait_idle();
        set_reg(CFG_CROUCH_TICKS, CW'(1));
        set_reg(CFG_FLIGHT_TICKS, CW'(2));
        push_req(CMD_TICK, '0);
        wait_idle();

        for (k = 0; k < 10; k++) begin
            case (k)
                0: begin
                    pc = 65535;
                    pf = 65535;
                    program_jump(65535, 65535, 65535, 65535, HMAX, HMIN, HMAX, HMIN);
                end
                1: begin
                    pc = 1;
                    pf = 2;
                    program_jump(1, 1, 1, 2, HMIN, HMAX, HMIN, HMAX);
                end
                2: begin
                    pc = $urandom_range(1, 4);
                    pf = 2;
                    program_jump(pc, 65535, 65535, pf, any_height(), any_height(),
                                 any_height(), any_height());
                end
                default: begin
                    pc = $urandom_range(1, 8);
                    pf = $urandom_range(2, 14);
                    program_jump(pc, $urandom_range(1, 6), $urandom_range(1, 6), pf,
                                 any_height(), any_height(), any_height(), any_height());
                end
            endcase
            quiet = (k % 4 == 3);
            n = 0;
            while (n < 150) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    push_req(1'($urandom_range(0, 1)), any_height());
                    n++;
                end else begin
                    push_req(CMD_START, any_height());
                    if (2 * pc + pf <= 60 && r >= 25) begin
                        ticks = 2 * pc + pf + $urandom_range(0, 3);
                    end else begin
                        ticks = $urandom_range(1, (2 * pc + pf < 40) ? 2 * pc + pf : 40);
                    end
                    repeat (ticks) push_req(CMD_TICK, any_height());
                    n += ticks + 1;
                end
            end
            wait_idle();
        end

        repeat (40) @(negedge i_clk);
        $display("%0d requests taken, %0d targets checked over %0d register settings",
                 reqs_taken, targets_checked, settings_count);
        $display("phase codes seen on the output: %b", seen_phases[5:0]);
        if (err_count == 0 && due_targets.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d targets still pending", due_targets.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
